// ----- hw/rtl/rc6_pkg.sv -----
// RC6 engine package: shared constants, types and helper functions.
// No dependencies.
package rc6_pkg;

    localparam int MAX_ROUNDS_DEF    = 20;
    localparam int MAX_KEY_WORDS_DEF = 8;

    localparam logic [31:0] MAGIC_P = 32'hB7E15163;
    localparam logic [31:0] MAGIC_Q = 32'h9E3779B9;

    typedef enum logic [1:0] {
        OP_EXPAND  = 2'd0,
        OP_ENCRYPT = 2'd1,
        OP_DECRYPT = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_ROUNDS  = 2'd1,
        ST_NOKEY   = 2'd2,
        ST_UNUSED  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        REG_ROUND_COUNT = 3'd0,
        REG_KEY_BITS    = 3'd1,
        REG_KEY_PART_0  = 3'd2,
        REG_KEY_PART_1  = 3'd3,
        REG_KEY_PART_2  = 3'd4,
        REG_KEY_PART_3  = 3'd5
    } reg_index_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_KLOAD,
        S_INIT,
        S_MIX_RD,
        S_MIX_A,
        S_MIX_B,
        S_CRYPT_PRE,
        S_CRYPT_RD,
        S_CRYPT_F,
        S_CRYPT_RND,
        S_CRYPT_POST,
        S_CRYPT_FIN,
        S_OUT
    } state_t;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] block_a;
        logic [31:0] block_b;
        logic [31:0] block_c;
        logic [31:0] block_d;
    } in_word_t;

    typedef struct packed {
        logic [31:0] result_a;
        logic [31:0] result_b;
        logic [31:0] result_c;
        logic [31:0] result_d;
        logic [1:0]  status;
    } out_word_t;

    function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] d;
        d = {x, x} << n;
        return d[63:32];
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] d;
        d = {x, x} >> n;
        return d[31:0];
    endfunction

endpackage

// ----- hw/rtl/rc6_if.sv -----
// Valid/ready channel carrying one word of type T.
// The payload type is given by parameter T; no package is imported.
interface rc6_if #(parameter type T = logic) (input logic clk);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/rc6_block_cipher.sv -----
// RC6-32/r/b engine; round keys and key words in synchronous memories.
// Encrypt/decrypt: per round one squaring step, two round-key reads through the single
// memory port and one update step; the result then goes to the output register.
// Expand: key load, table init, then 3*max(c,2r+4) mix passes (read, A update, B update).
// Status-only answers go straight to the output state. One word in the core at a time; the output
// register holds a result until taken. Reset initialises control and config, not memories.
module rc6_block_cipher #(
    parameter int MAX_ROUNDS    = rc6_pkg::MAX_ROUNDS_DEF,
    parameter int MAX_KEY_WORDS = rc6_pkg::MAX_KEY_WORDS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    rc6_if.sink         in_ch,
    rc6_if.source       out_ch,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);
    import rc6_pkg::*;

    localparam int RK_DEPTH = 2 * MAX_ROUNDS + 4;
    localparam int RKW      = $clog2(RK_DEPTH);
    localparam int KWW      = (MAX_KEY_WORDS > 1) ? $clog2(MAX_KEY_WORDS) : 1;
    localparam int CW       = KWW + 1;

    logic [6:0]  round_count_reg;
    logic [8:0]  key_bits_reg;
    logic [63:0] key_part_reg [4];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            round_count_reg <= 7'd20;
            key_bits_reg    <= 9'd128;
            for (int i = 0; i < 4; i++)
                key_part_reg[i] <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ROUND_COUNT: round_count_reg <= cfg_data[6:0];
                REG_KEY_BITS:    key_bits_reg    <= cfg_data[8:0];
                REG_KEY_PART_0:  key_part_reg[0] <= cfg_data;
                REG_KEY_PART_1:  key_part_reg[1] <= cfg_data;
                REG_KEY_PART_2:  key_part_reg[2] <= cfg_data;
                REG_KEY_PART_3:  key_part_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    // memories
    logic [31:0] rk_mem [RK_DEPTH];
    logic [31:0] kw_mem [MAX_KEY_WORDS];
    logic            rk_we;
    logic [RKW-1:0]  rk_waddr, rk_raddr;
    logic [31:0]     rk_wdata, rk_rdata;
    logic            kw_we;
    logic [KWW-1:0]  kw_waddr, kw_raddr;
    logic [31:0]     kw_wdata, kw_rdata;

    always_ff @(posedge clk)
    begin
        if (rk_we)
            rk_mem[rk_waddr] <= rk_wdata;
        rk_rdata <= rk_mem[rk_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (kw_we)
            kw_mem[kw_waddr] <= kw_wdata;
        kw_rdata <= kw_mem[kw_raddr];
    end

    // control and datapath registers
    state_t      state_reg, state_next;
    logic        ready_flag_reg, ready_flag_next;
    logic [6:0]  act_rounds_reg, act_rounds_next;
    logic        out_valid_reg, out_valid_next;
    out_word_t   out_reg, out_next;
    out_word_t   res_reg, res_next;
    logic [1:0]  op_reg, op_next;
    logic [31:0] a_reg, a_next, b_reg, b_next, c_reg, c_next, d_reg, d_next;
    logic [31:0] t_reg, t_next;
    logic [31:0] ma_reg, ma_next, mb_reg, mb_next;
    logic [RKW-1:0] i_reg, i_next;
    logic [KWW-1:0] j_reg, j_next;
    logic [11:0] p_reg, p_next;
    logic [6:0]  k_reg, k_next;
    logic [1:0]  ph_reg, ph_next;
    logic [6:0]  er_reg, er_next;
    logic [CW-1:0] nc_reg, nc_next;
    logic [7:0]  nt_reg, nt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            ready_flag_reg <= 1'b0;
            act_rounds_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            ready_flag_reg <= ready_flag_next;
            act_rounds_reg <= act_rounds_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        res_reg <= res_next;
        op_reg <= op_next;
        a_reg <= a_next; b_reg <= b_next; c_reg <= c_next; d_reg <= d_next;
        t_reg <= t_next;
        ma_reg <= ma_next; mb_reg <= mb_next;
        i_reg <= i_next; j_reg <= j_next; p_reg <= p_next; k_reg <= k_next;
        ph_reg <= ph_next; er_reg <= er_next; nc_reg <= nc_next; nt_reg <= nt_next;
    end

    assign in_ch.ready  = (state_reg == S_IDLE);
    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_reg;

    // key length decode
    logic [8:0] bits_sat;
    logic [5:0] c_raw;
    logic [CW-1:0] c_words;
    logic [4:0] rem_bits;
    logic [2:0] nbytes;
    always_comb
    begin
        bits_sat = (key_bits_reg == 9'd0) ? 9'd1 :
                   (key_bits_reg > 9'd256) ? 9'd256 : key_bits_reg;
        c_raw    = 6'((10'(bits_sat) + 10'd31) >> 5);
        c_words  = (c_raw > 6'(MAX_KEY_WORDS)) ? CW'(MAX_KEY_WORDS) : CW'(c_raw);
        rem_bits = bits_sat[4:0];
        nbytes   = 3'((6'(rem_bits) + 6'd7) >> 3);
    end

    // key word for load index j
    logic [63:0] kp_sel;
    logic [31:0] kw_load;
    always_comb
    begin
        kp_sel  = key_part_reg[2'(j_reg >> 1)];
        kw_load = j_reg[0] ? kp_sel[63:32] : kp_sel[31:0];
        if ((CW'(j_reg) == nc_reg - CW'(1)) && (rem_bits != 5'd0) && (nbytes < 3'd4))
            kw_load = kw_load & ((32'd1 << {nbytes, 3'b000}) - 32'd1);
    end

    logic [31:0] sq_b, sq_d, f_b, f_d, a_mix, b_sum, b_mix;
    always_comb
    begin
        sq_b  = b_reg * {b_reg[30:0], 1'b1};
        sq_d  = d_reg * {d_reg[30:0], 1'b1};
        f_b   = rotl(ma_reg, 5'd5);
        f_d   = rotl(mb_reg, 5'd5);
        a_mix = rotl(rk_rdata + a_reg + b_reg, 5'd3);
        b_sum = a_reg + b_reg;
        b_mix = rotl(kw_rdata + b_sum, b_sum[4:0]);
    end

    logic [RKW-1:0] rk_last;
    assign rk_last = RKW'(nt_reg - 8'd1);

    always_comb
    begin
        state_next = state_reg;
        ready_flag_next = ready_flag_reg;
        act_rounds_next = act_rounds_reg;
        out_valid_next = out_valid_reg;
        out_next = out_reg;
        res_next = res_reg;
        op_next = op_reg;
        a_next = a_reg; b_next = b_reg; c_next = c_reg; d_next = d_reg;
        t_next = t_reg; ma_next = ma_reg; mb_next = mb_reg;
        i_next = i_reg; j_next = j_reg; p_next = p_reg; k_next = k_reg;
        ph_next = ph_reg; er_next = er_reg; nc_next = nc_reg; nt_next = nt_reg;
        rk_we = 1'b0; rk_waddr = i_reg; rk_wdata = a_reg; rk_raddr = i_reg;
        kw_we = 1'b0; kw_waddr = j_reg; kw_wdata = kw_load; kw_raddr = j_reg;

        if (out_ch.valid && out_ch.ready)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid && in_ch.ready)
                begin
                    op_next = in_ch.data.op;
                    a_next = in_ch.data.block_a; b_next = in_ch.data.block_b;
                    c_next = in_ch.data.block_c; d_next = in_ch.data.block_d;
                    res_next = '0;
                    case (op_t'(in_ch.data.op))
                        OP_EXPAND:
                        begin
                            if (round_count_reg > 7'(MAX_ROUNDS))
                            begin
                                res_next.status = ST_ROUNDS;
                                state_next = S_OUT;
                            end
                            else
                            begin
                                er_next = round_count_reg;
                                nt_next = {round_count_reg, 1'b0} + 8'd4;
                                nc_next = c_words;
                                j_next = '0;
                                state_next = S_KLOAD;
                            end
                        end
                        OP_ENCRYPT, OP_DECRYPT:
                        begin
                            if (!ready_flag_reg)
                            begin
                                res_next.status = ST_NOKEY;
                                state_next = S_OUT;
                            end
                            else
                            begin
                                state_next = S_CRYPT_PRE;
                                ph_next = 2'd0;
                            end
                        end
                        default: state_next = S_OUT;
                    endcase
                end
            end
            S_KLOAD:
            begin
                kw_we = 1'b1;
                if (CW'(j_reg) == nc_reg - CW'(1))
                begin
                    i_next = '0;
                    a_next = MAGIC_P;
                    state_next = S_INIT;
                end
                else
                    j_next = j_reg + KWW'(1);
            end
            S_INIT:
            begin
                rk_we = 1'b1; rk_waddr = i_reg; rk_wdata = a_reg;
                a_next = a_reg + MAGIC_Q;
                if (i_reg == rk_last)
                begin
                    i_next = '0; j_next = '0; a_next = '0; b_next = '0;
                    p_next = 12'(3) * 12'((8'(nc_reg) > nt_reg) ? 8'(nc_reg) : nt_reg);
                    state_next = S_MIX_RD;
                end
                else
                    i_next = i_reg + RKW'(1);
            end
            S_MIX_RD:
            begin
                rk_raddr = i_reg; kw_raddr = j_reg;
                state_next = S_MIX_A;
            end
            S_MIX_A:
            begin
                rk_we = 1'b1; rk_waddr = i_reg; rk_wdata = a_mix;
                a_next = a_mix;
                state_next = S_MIX_B;
            end
            S_MIX_B:
            begin
                kw_we = 1'b1; kw_waddr = j_reg; kw_wdata = b_mix;
                b_next = b_mix;
                i_next = (i_reg == rk_last) ? '0 : i_reg + RKW'(1);
                j_next = (CW'(j_reg) == nc_reg - CW'(1)) ? '0 : j_reg + KWW'(1);
                p_next = p_reg - 12'd1;
                if (p_reg == 12'd1)
                begin
                    act_rounds_next = er_reg;
                    ready_flag_next = 1'b1;
                    res_next = '0;
                    state_next = S_OUT;
                end
                else
                    state_next = S_MIX_RD;
            end
            S_CRYPT_PRE:
            begin
                // ph 0 reads key 0 (or 2r+2), ph 1 reads key 1 (or 2r+3)
                if (op_reg == OP_ENCRYPT)
                    rk_raddr = RKW'(ph_reg);
                else
                    rk_raddr = RKW'({act_rounds_reg, 1'b0} + 8'd2 + 8'(ph_reg));
                if (ph_reg == 2'd1)
                    state_next = S_CRYPT_RD;
                ph_next = ph_reg + 2'd1;
                if (ph_reg == 2'd1)
                begin
                    if (op_reg == OP_ENCRYPT)
                        b_next = b_reg + rk_rdata;
                    else
                        a_next = a_reg - rk_rdata;
                end
            end
            S_CRYPT_RD:
            begin
                if (op_reg == OP_ENCRYPT)
                begin
                    d_next = d_reg + rk_rdata;
                    k_next = 7'd1;
                end
                else
                begin
                    c_next = c_reg - rk_rdata;
                    k_next = act_rounds_reg;
                    // pre-rotate for the first decrypt round
                    if (act_rounds_reg != 7'd0)
                    begin
                        a_next = d_reg; b_next = a_reg; c_next = b_reg;
                        d_next = c_reg - rk_rdata;
                    end
                end
                if (act_rounds_reg == 7'd0)
                    state_next = S_CRYPT_POST;
                else
                    state_next = S_CRYPT_F;
            end
            S_CRYPT_F:
            begin
                ma_next = sq_b; mb_next = sq_d;
                rk_raddr = RKW'({k_reg, 1'b0});
                state_next = S_CRYPT_RND;
                ph_next = 2'd0;
            end
            S_CRYPT_RND:
            begin
                rk_raddr = RKW'({k_reg, 1'b1});
                if (ph_reg == 2'd0)
                begin
                    t_next = rk_rdata;
                    ph_next = 2'd1;
                end
                else
                begin
                    if (op_reg == OP_ENCRYPT)
                    begin
                        a_next = b_reg;
                        b_next = rotl(c_reg ^ f_d, f_b[4:0]) + rk_rdata;
                        c_next = d_reg;
                        d_next = rotl(a_reg ^ f_b, f_d[4:0]) + t_reg;
                    end
                    else
                    begin
                        a_next = rotr(a_reg - t_reg, f_d[4:0]) ^ f_b;
                        c_next = rotr(c_reg - rk_rdata, f_b[4:0]) ^ f_d;
                    end
                    state_next = S_CRYPT_POST;
                end
            end
            S_CRYPT_POST:
            begin
                if (op_reg == OP_DECRYPT && k_reg != 7'd0 && act_rounds_reg != 7'd0)
                begin
                    if (k_reg == 7'd1)
                    begin
                        k_next = 7'd0;
                        rk_raddr = RKW'(1);
                        state_next = S_CRYPT_FIN;
                        ph_next = 2'd0;
                    end
                    else
                    begin
                        k_next = k_reg - 7'd1;
                        a_next = d_reg; b_next = a_reg; c_next = b_reg; d_next = c_reg;
                        state_next = S_CRYPT_F;
                    end
                end
                else if (op_reg == OP_ENCRYPT && k_reg != act_rounds_reg
                         && act_rounds_reg != 7'd0)
                begin
                    k_next = k_reg + 7'd1;
                    state_next = S_CRYPT_F;
                end
                else
                begin
                    if (op_reg == OP_ENCRYPT)
                        rk_raddr = RKW'({act_rounds_reg, 1'b0} + 8'd2);
                    else
                        rk_raddr = RKW'(1);
                    state_next = S_CRYPT_FIN;
                    ph_next = 2'd0;
                end
            end
            S_CRYPT_FIN:
            begin
                if (op_reg == OP_ENCRYPT)
                    rk_raddr = RKW'({act_rounds_reg, 1'b0} + 8'd3);
                else
                    rk_raddr = RKW'(0);
                if (ph_reg == 2'd0)
                    ph_next = 2'd1;
                else if (ph_reg == 2'd1)
                begin
                    if (op_reg == OP_ENCRYPT)
                        a_next = a_reg + t_reg;
                    else
                        d_next = d_reg - t_reg;
                    ph_next = 2'd2;
                end
                else
                begin
                    res_next.result_a = a_reg;
                    res_next.result_b = (op_reg == OP_ENCRYPT) ? b_reg : b_reg - rk_rdata;
                    res_next.result_c = (op_reg == OP_ENCRYPT) ? c_reg + rk_rdata : c_reg;
                    res_next.result_d = d_reg;
                    res_next.status = ST_OK;
                    state_next = S_OUT;
                end
                if (ph_reg == 2'd0)
                    t_next = rk_rdata;
            end
            S_OUT:
            begin
                // hold until the output register is free or being taken
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_next = res_reg;
                    out_valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Note: FIN phase 0 latches the read issued by POST (2r+2 or key 1).

    property p_no_accept_busy;
        @(posedge clk) disable iff (!rst_n) (state_reg != S_IDLE) |-> !in_ch.ready;
    endproperty
    assert property (p_no_accept_busy) else $error("accept while busy");

    property p_out_hold;
        @(posedge clk) disable iff (!rst_n)
            (out_ch.valid && !out_ch.ready) |=> out_ch.valid;
    endproperty
    assert property (p_out_hold) else $error("result dropped");

    property p_out_stable;
        @(posedge clk) disable iff (!rst_n)
            (out_ch.valid && !out_ch.ready) |=> $stable(out_ch.data);
    endproperty
    assert property (p_out_stable) else $error("result changed while waiting");

    property p_ready_rounds;
        @(posedge clk) disable iff (!rst_n)
            ready_flag_reg |-> (act_rounds_reg <= 7'(MAX_ROUNDS));
    endproperty
    assert property (p_ready_rounds) else $error("bad active round count");

endmodule
